### sv/motor_feedback_turn_tracker_top_defines.svh
// assertion macros for the motor feedback turn tracker
`ifndef MOTOR_FEEDBACK_TURN_TRACKER_TOP_DEFINES_SVH
`define MOTOR_FEEDBACK_TURN_TRACKER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled while in reset
`define MFTT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define MFTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MFTT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)

`define MFTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### sv/mftt_pkg.sv
// shared types and constants of the motor feedback turn tracker
package mftt_pkg;

    // slot count and configuration layout
    localparam int SLOTS_DEF  = 4;
    localparam int CFG_SLOTS  = 4;
    localparam int ID_W       = 11;
    localparam int KIND_W     = 2;
    localparam int IDS_W      = 44;
    localparam int KINDS_W    = 8;
    localparam int BUSES_W    = 4;
    localparam int LIMIT_W    = 16;
    localparam int CFG_DATA_W = 44;
    localparam int CFG_IDX_W  = 2;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 16'd200;

    // word field widths
    localparam int LEN_W   = 4;
    localparam int DATA_W  = 64;
    localparam int ANGLE_W = 16;
    localparam int SPEED_W = 24;
    localparam int CURR_W  = 16;
    localparam int TEMP_W  = 8;
    localparam int TURN_W  = 15;
    localparam int SHAFT_W = 39;
    localparam int TICK_W  = 32;

    localparam logic [LEN_W-1:0] FULL_LEN = 4'd8;

    // wrap detection
    localparam int THR_GEARED = 4096;
    localparam int THR_DIRECT = 5500;
    localparam int TURN_CLEAR = 10000;
    localparam int TURN_SHIFT = 13;

    // shaft angle: n * 2880 / ratio, ratio 19 split as n * 151 + n * 11 / 19
    localparam int SHAFT_K_R36    = 80;
    localparam int SHAFT_K_R19    = 151;
    localparam int SHAFT_K_DIRECT = 2880;
    localparam int SHAFT_REM_R19  = 11;
    localparam int HALF_R19       = 9;
    localparam int HALF_R36       = 18;

    // reciprocals for exact floor division
    localparam logic [30:0] SHAFT_RECIP_R19 = 31'd1808407283;
    localparam int          SHAFT_SH_R19    = 35;
    localparam logic [24:0] SPD_RECIP_R36   = 25'd29826162;
    localparam int          SPD_SH_R36      = 30;
    localparam logic [24:0] SPD_RECIP_R19   = 25'd28256364;
    localparam int          SPD_SH_R19      = 29;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOT_IDS   = 2'd0,
        CFG_SLOT_KINDS = 2'd1,
        CFG_SLOT_BUSES = 2'd2,
        CFG_SILENCE    = 2'd3
    } cfg_reg_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ABSENT = 2'd0,
        KIND_R36    = 2'd1,
        KIND_R19    = 2'd2,
        KIND_DIRECT = 2'd3
    } motor_kind_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] prev_angle;
        logic [TURN_W-1:0]  turns;
    } turn_entry_t;

endpackage

### sv/motor_feedback_turn_tracker_top.sv
// motor feedback turn tracker: slot match, turn memory update and fixed-point scaling
//
// channel | handshake          | payload
// s_      | s_valid / s_ready  | action, bus_num, frame_id, frame_len, frame_data
// m_      | m_valid / m_ready  | matched .. any_offline, one word per input word
// cfg_    | cfg_wr_en          | cfg_index, cfg_wdata
//
// one word a cycle unless m_ready stalls; results pass stages 1-4, then the output reg
// the pace is set by the turn memory read-modify-write in stage 1, which a bypass
// register covers when consecutive frames hit the same slot
// reset clears control, seen bits, heard stamps and the tick counter; the turn
// memory is not cleared, an unseen slot reads as zero turns
// the whole pipe holds while a result waits on m_ready
`include "motor_feedback_turn_tracker_top_defines.svh"

module motor_feedback_turn_tracker_top #(
    parameter int SLOTS = mftt_pkg::SLOTS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [mftt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mftt_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input words
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_action,
    input  logic                                s_bus_num,
    input  logic [mftt_pkg::ID_W-1:0]           s_frame_id,
    input  logic [mftt_pkg::LEN_W-1:0]          s_frame_len,
    input  logic [mftt_pkg::DATA_W-1:0]         s_frame_data,
    // result words
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_matched,
    output logic [1:0]                          m_slot_index,
    output logic signed [mftt_pkg::ANGLE_W-1:0] m_raw_angle,
    output logic signed [mftt_pkg::SPEED_W-1:0] m_speed_scaled,
    output logic signed [mftt_pkg::CURR_W-1:0]  m_motor_current,
    output logic [mftt_pkg::TEMP_W-1:0]         m_temperature,
    output logic signed [mftt_pkg::TURN_W-1:0]  m_turn_count,
    output logic signed [mftt_pkg::SHAFT_W-1:0] m_shaft_angle,
    output logic                                m_slot_offline,
    output logic                                m_any_offline
);
    import mftt_pkg::*;

    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NUM_W   = 28;
    localparam int REM_W   = 30;
    localparam int Q19_W   = 26;
    localparam int XSP_W   = 24;
    localparam int SPROD_W = 54;

    // configuration registers
    logic [IDS_W-1:0]   slot_ids_reg;
    logic [KINDS_W-1:0] slot_kinds_reg;
    logic [BUSES_W-1:0] slot_buses_reg;
    logic [LIMIT_W-1:0] silence_reg;

    logic [ID_W-1:0] slot_id   [SLOTS];
    motor_kind_t     slot_kind [SLOTS];
    logic            slot_bus  [SLOTS];

    // per-slot flip-flop state
    logic [SLOTS-1:0]  seen_reg;
    logic [TICK_W-1:0] last_heard_reg [SLOTS];
    logic [TICK_W-1:0] tick_now_reg;

    // turn memory and its read side
    turn_entry_t turn_mem [SLOTS];
    turn_entry_t rd_data_reg;
    turn_entry_t byp_data_reg;
    logic        byp_reg;

    logic advance;
    logic s_acc;

    // stage 0 match
    logic              sel_found;
    logic              sel_hit;
    logic [SLOT_W-1:0] sel_slot;
    motor_kind_t       sel_kind;

    // stage 1
    logic                     v1_reg, tick1_reg, hit1_reg;
    logic [SLOT_W-1:0]        slot1_reg;
    motor_kind_t              kind1_reg;
    logic signed [ANGLE_W-1:0] ang1_reg, spd1_reg, cur1_reg;
    logic [TEMP_W-1:0]        temp1_reg;

    turn_entry_t              entry1;
    logic signed [ANGLE_W-1:0] prev1;
    logic signed [16:0]       diff1, thr1;
    logic signed [15:0]       cnt_raw1;
    logic signed [TURN_W-1:0] cnt1;
    logic signed [NUM_W-1:0]  num1;
    logic [ANGLE_W-1:0]       spd_mag1;
    logic [XSP_W-1:0]         xsp1;
    logic                     mem_we;
    turn_entry_t              wr_entry;

    // stage 2
    logic                     v2_reg, hit2_reg, spneg2_reg;
    logic [SLOT_W-1:0]        slot2_reg;
    motor_kind_t              kind2_reg;
    logic signed [ANGLE_W-1:0] ang2_reg, spd2_reg, cur2_reg;
    logic [TEMP_W-1:0]        temp2_reg;
    logic signed [TURN_W-1:0] cnt2_reg;
    logic signed [NUM_W-1:0]  num2_reg;
    logic [XSP_W-1:0]         xsp2_reg;

    logic [SLOTS-1:0]         off2;
    logic [11:0]              shaft_k2;
    logic signed [40:0]       base_full2;
    logic [NUM_W-1:0]         num_mag2;
    logic [REM_W-1:0]         rem2;
    logic [24:0]              spd_recip2;
    logic [SPROD_W-1:0]       sprod2;

    // stage 3
    logic                     v3_reg, hit3_reg, spneg3_reg, nneg3_reg;
    logic                     slot_off3_reg, any_off3_reg;
    logic [SLOT_W-1:0]        slot3_reg;
    motor_kind_t              kind3_reg;
    logic signed [ANGLE_W-1:0] ang3_reg, spd3_reg, cur3_reg;
    logic [TEMP_W-1:0]        temp3_reg;
    logic signed [TURN_W-1:0] cnt3_reg;
    logic signed [SHAFT_W-1:0] base3_reg;
    logic [REM_W-1:0]         rem3_reg;
    logic [SPROD_W-1:0]       sprod3_reg;

    logic [60:0]              q19_full3;
    logic [XSP_W-1:0]         spq3;
    logic signed [SPEED_W-1:0] speed3;

    // stage 4
    logic                     v4_reg, hit4_reg, nneg4_reg;
    logic                     slot_off4_reg, any_off4_reg;
    logic [SLOT_W-1:0]        slot4_reg;
    motor_kind_t              kind4_reg;
    logic signed [ANGLE_W-1:0] ang4_reg, cur4_reg;
    logic [TEMP_W-1:0]        temp4_reg;
    logic signed [TURN_W-1:0] cnt4_reg;
    logic signed [SHAFT_W-1:0] base4_reg;
    logic [Q19_W-1:0]         q19_4_reg;
    logic signed [SPEED_W-1:0] speed4_reg;
    logic signed [SHAFT_W-1:0] shaft4;
    logic signed [SHAFT_W-1:0] q19_signed4;

    // output register
    logic                      m_valid_reg;
    logic                      m_matched_reg;
    logic [1:0]                m_slot_index_reg;
    logic signed [ANGLE_W-1:0] m_raw_angle_reg;
    logic signed [SPEED_W-1:0] m_speed_scaled_reg;
    logic signed [CURR_W-1:0]  m_motor_current_reg;
    logic [TEMP_W-1:0]         m_temperature_reg;
    logic signed [TURN_W-1:0]  m_turn_count_reg;
    logic signed [SHAFT_W-1:0] m_shaft_angle_reg;
    logic                      m_slot_offline_reg;
    logic                      m_any_offline_reg;

    // pipe moves as one while the output register can take a word
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance && aresetn;
    assign s_acc   = s_valid && s_ready;

    // configuration write port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_ids_reg   <= '0;
            slot_kinds_reg <= '0;
            slot_buses_reg <= '0;
            silence_reg    <= LIMIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                CFG_SLOT_IDS:   slot_ids_reg   <= cfg_wdata[IDS_W-1:0];
                CFG_SLOT_KINDS: slot_kinds_reg <= cfg_wdata[KINDS_W-1:0];
                CFG_SLOT_BUSES: slot_buses_reg <= cfg_wdata[BUSES_W-1:0];
                CFG_SILENCE:    silence_reg    <= cfg_wdata[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // unpack slot settings, slots past the register layout stay absent
    for (genvar gi = 0; gi < SLOTS; gi++) begin : g_slot_cfg
        if (gi < CFG_SLOTS) begin : g_cfg
            assign slot_id[gi]   = slot_ids_reg[gi*ID_W +: ID_W];
            assign slot_kind[gi] = motor_kind_t'(slot_kinds_reg[gi*KIND_W +: KIND_W]);
            assign slot_bus[gi]  = slot_buses_reg[gi];
        end else begin : g_none
            assign slot_id[gi]   = '0;
            assign slot_kind[gi] = KIND_ABSENT;
            assign slot_bus[gi]  = 1'b0;
        end
    end

    // lowest matching present slot; short frames for ratio-36 kind are dropped
    always_comb begin
        sel_found = 1'b0;
        sel_slot  = '0;
        sel_kind  = KIND_ABSENT;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (slot_kind[i] != KIND_ABSENT && slot_bus[i] == s_bus_num &&
                slot_id[i] == s_frame_id) begin
                sel_found = 1'b1;
                sel_slot  = SLOT_W'(i);
                sel_kind  = slot_kind[i];
            end
        end
        sel_hit = !s_action && sel_found &&
                  !(sel_kind == KIND_R36 && s_frame_len != FULL_LEN);
    end

    // turn memory: read on accept, write back from stage 1, bypass on same-slot overlap
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            turn_mem[slot1_reg] <= wr_entry;
        end
        if (s_acc) begin
            rd_data_reg  <= turn_mem[sel_slot];
            byp_reg      <= mem_we && (slot1_reg == sel_slot);
            byp_data_reg <= wr_entry;
        end
    end

    // stage 1 payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            tick1_reg <= s_action;
            hit1_reg  <= sel_hit;
            slot1_reg <= sel_slot;
            kind1_reg <= sel_kind;
            ang1_reg  <= $signed(s_frame_data[63:48]);
            spd1_reg  <= $signed(s_frame_data[47:32]);
            cur1_reg  <= $signed(s_frame_data[31:16]);
            temp1_reg <= (sel_kind == KIND_R19) ? s_frame_data[15:8] : '0;
        end
    end

    // stage 1: wrap detection, count clearing, numerators
    always_comb begin
        entry1 = byp_reg ? byp_data_reg : rd_data_reg;
        if (seen_reg[slot1_reg]) begin
            prev1    = $signed(entry1.prev_angle);
            cnt_raw1 = 16'($signed(entry1.turns));
        end else begin
            prev1    = ang1_reg;
            cnt_raw1 = '0;
        end
        diff1 = 17'(ang1_reg) - 17'(prev1);
        thr1  = (kind1_reg == KIND_DIRECT) ? 17'(THR_DIRECT) : 17'(THR_GEARED);
        if (diff1 < -thr1) begin
            cnt_raw1 = cnt_raw1 + 16'sd1;
        end else if (diff1 > thr1) begin
            cnt_raw1 = cnt_raw1 - 16'sd1;
        end
        if (cnt_raw1 > 16'(TURN_CLEAR) || cnt_raw1 < -16'(TURN_CLEAR)) begin
            cnt1 = '0;
        end else begin
            cnt1 = cnt_raw1[TURN_W-1:0];
        end
        num1 = (NUM_W'(cnt1) <<< TURN_SHIFT) + NUM_W'(ang1_reg);
        spd_mag1 = spd1_reg[ANGLE_W-1] ? 16'(-spd1_reg) : 16'(spd1_reg);
        case (kind1_reg)
            KIND_R36: xsp1 = {spd_mag1, 8'd0} + XSP_W'(HALF_R36);
            KIND_R19: xsp1 = {spd_mag1, 8'd0} + XSP_W'(HALF_R19);
            default:  xsp1 = {spd_mag1, 8'd0};
        endcase
        wr_entry.prev_angle = ang1_reg;
        wr_entry.turns      = cnt1;
        mem_we = advance && v1_reg && hit1_reg;
    end

    // slot bookkeeping and tick counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg     <= '0;
            tick_now_reg <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                last_heard_reg[i] <= '0;
            end
        end else begin
            if (mem_we) begin
                seen_reg[slot1_reg]       <= 1'b1;
                last_heard_reg[slot1_reg] <= tick_now_reg;
            end
            if (advance && v1_reg && tick1_reg) begin
                tick_now_reg <= tick_now_reg + 1'b1;
            end
        end
    end

    // stage 2 payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            hit2_reg   <= hit1_reg;
            slot2_reg  <= slot1_reg;
            kind2_reg  <= kind1_reg;
            ang2_reg   <= ang1_reg;
            spd2_reg   <= spd1_reg;
            cur2_reg   <= cur1_reg;
            temp2_reg  <= temp1_reg;
            cnt2_reg   <= cnt1;
            num2_reg   <= num1;
            xsp2_reg   <= xsp1;
            spneg2_reg <= spd1_reg[ANGLE_W-1];
        end
    end

    // stage 2: offline flags from settled state, constant multiplies
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            off2[i] = (slot_kind[i] != KIND_ABSENT) &&
                      ((tick_now_reg - last_heard_reg[i]) >= TICK_W'(silence_reg));
        end
        case (kind2_reg)
            KIND_R36: begin
                shaft_k2   = 12'(SHAFT_K_R36);
                spd_recip2 = SPD_RECIP_R36;
            end
            KIND_R19: begin
                shaft_k2   = 12'(SHAFT_K_R19);
                spd_recip2 = SPD_RECIP_R19;
            end
            default: begin
                shaft_k2   = 12'(SHAFT_K_DIRECT);
                spd_recip2 = SPD_RECIP_R19;
            end
        endcase
        base_full2 = 41'(num2_reg) * $signed({1'b0, shaft_k2});
        num_mag2   = num2_reg[NUM_W-1] ? NUM_W'(-num2_reg) : NUM_W'(num2_reg);
        rem2       = REM_W'(num_mag2) * REM_W'(SHAFT_REM_R19) + REM_W'(HALF_R19);
        sprod2     = SPROD_W'(xsp2_reg) * SPROD_W'(spd_recip2);
    end

    // stage 3 payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            hit3_reg      <= hit2_reg;
            slot3_reg     <= slot2_reg;
            kind3_reg     <= kind2_reg;
            ang3_reg      <= ang2_reg;
            spd3_reg      <= spd2_reg;
            cur3_reg      <= cur2_reg;
            temp3_reg     <= temp2_reg;
            cnt3_reg      <= cnt2_reg;
            spneg3_reg    <= spneg2_reg;
            nneg3_reg     <= num2_reg[NUM_W-1];
            base3_reg     <= base_full2[SHAFT_W-1:0];
            rem3_reg      <= rem2;
            sprod3_reg    <= sprod2;
            slot_off3_reg <= hit2_reg && off2[slot2_reg];
            any_off3_reg  <= |off2;
        end
    end

    // stage 3: reciprocal quotient for ratio 19, speed quotient and sign
    always_comb begin
        q19_full3 = 61'(rem3_reg) * 61'(SHAFT_RECIP_R19);
        if (kind3_reg == KIND_R36) begin
            spq3 = sprod3_reg[SPD_SH_R36 +: XSP_W];
        end else begin
            spq3 = sprod3_reg[SPD_SH_R19 +: XSP_W];
        end
        if (kind3_reg == KIND_DIRECT) begin
            speed3 = {spd3_reg, 8'd0};
        end else if (spneg3_reg) begin
            speed3 = -$signed(spq3);
        end else begin
            speed3 = $signed(spq3);
        end
    end

    // stage 4 payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            hit4_reg      <= hit3_reg;
            slot4_reg     <= slot3_reg;
            kind4_reg     <= kind3_reg;
            ang4_reg      <= ang3_reg;
            cur4_reg      <= cur3_reg;
            temp4_reg     <= temp3_reg;
            cnt4_reg      <= cnt3_reg;
            nneg4_reg     <= nneg3_reg;
            base4_reg     <= base3_reg;
            q19_4_reg     <= q19_full3[SHAFT_SH_R19 +: Q19_W];
            speed4_reg    <= speed3;
            slot_off4_reg <= slot_off3_reg;
            any_off4_reg  <= any_off3_reg;
        end
    end

    // stage 4: fold the ratio-19 remainder into the shaft angle
    always_comb begin
        q19_signed4 = nneg4_reg ? -SHAFT_W'(q19_4_reg) : SHAFT_W'(q19_4_reg);
        if (kind4_reg == KIND_R19) begin
            shaft4 = base4_reg + q19_signed4;
        end else begin
            shaft4 = base4_reg;
        end
    end

    // stage valids and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            v1_reg      <= s_acc;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            m_valid_reg <= v4_reg;
        end
    end

    // output word; unmatched words carry only the offline summary
    always_ff @(posedge aclk) begin
        if (advance) begin
            m_matched_reg      <= hit4_reg;
            m_any_offline_reg  <= any_off4_reg;
            if (hit4_reg) begin
                m_slot_index_reg    <= 2'(slot4_reg);
                m_raw_angle_reg     <= ang4_reg;
                m_speed_scaled_reg  <= speed4_reg;
                m_motor_current_reg <= cur4_reg;
                m_temperature_reg   <= temp4_reg;
                m_turn_count_reg    <= cnt4_reg;
                m_shaft_angle_reg   <= shaft4;
                m_slot_offline_reg  <= slot_off4_reg;
            end else begin
                m_slot_index_reg    <= '0;
                m_raw_angle_reg     <= '0;
                m_speed_scaled_reg  <= '0;
                m_motor_current_reg <= '0;
                m_temperature_reg   <= '0;
                m_turn_count_reg    <= '0;
                m_shaft_angle_reg   <= '0;
                m_slot_offline_reg  <= 1'b0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_matched       = m_matched_reg;
    assign m_slot_index    = m_slot_index_reg;
    assign m_raw_angle     = m_raw_angle_reg;
    assign m_speed_scaled  = m_speed_scaled_reg;
    assign m_motor_current = m_motor_current_reg;
    assign m_temperature   = m_temperature_reg;
    assign m_turn_count    = m_turn_count_reg;
    assign m_shaft_angle   = m_shaft_angle_reg;
    assign m_slot_offline  = m_slot_offline_reg;
    assign m_any_offline   = m_any_offline_reg;

    // checks
    `MFTT_ASSERT_IMP(a_turn_range, aclk, aresetn, m_valid_reg && m_matched_reg, (m_turn_count_reg <= 15'sd10000) && (m_turn_count_reg >= -15'sd10000), "turn count outside clearing range")
    `MFTT_ASSERT_IMP(a_unmatched_quiet, aclk, aresetn, m_valid_reg && !m_matched_reg, (m_shaft_angle_reg == '0) && (m_turn_count_reg == '0) && !m_slot_offline_reg, "unmatched word carries slot data")
    `MFTT_ASSERT_IMP(a_slot_off_any, aclk, aresetn, m_valid_reg && m_slot_offline_reg, m_any_offline_reg, "slot offline without summary flag")
    `MFTT_ASSERT_NEXT(a_tick_step, aclk, aresetn, advance && v1_reg && tick1_reg, tick_now_reg == $past(tick_now_reg) + 1'b1, "tick counter did not step")
    `MFTT_ASSERT_NEXT(a_frame_stamp, aclk, aresetn, mem_we, seen_reg[$past(slot1_reg)] && (last_heard_reg[$past(slot1_reg)] == $past(tick_now_reg)), "slot not stamped on frame")

endmodule

### test/motor_feedback_turn_tracker_top_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the motor feedback turn tracker top level
module motor_feedback_turn_tracker_top_tb;
    import mftt_pkg::*;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 6;
    localparam int QUIET_LIMIT     = 4000;
    localparam int SETTLE_CYCLES   = 10;
    localparam int RANDOM_PHASES   = 8;
    localparam int WORDS_PER_PHASE = 130;
    localparam int SWEEP_TURNS     = 8;
    localparam int MAX_REPORTS     = 200;
    localparam logic [ID_W-1:0] SWEEP_ID = 11'h155;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct {
        logic              action;
        logic              bus_num;
        logic [ID_W-1:0]   frame_id;
        logic [LEN_W-1:0]  frame_len;
        logic [DATA_W-1:0] frame_data;
    } feedback_word_t;

    typedef struct {
        logic                      matched;
        logic [1:0]                slot_index;
        logic signed [ANGLE_W-1:0] raw_angle;
        logic signed [SPEED_W-1:0] speed_scaled;
        logic signed [CURR_W-1:0]  motor_current;
        logic [TEMP_W-1:0]         temperature;
        logic signed [TURN_W-1:0]  turn_count;
        logic signed [SHAFT_W-1:0] shaft_angle;
        logic                      slot_offline;
        logic                      any_offline;
    } tracker_result_t;

    // turn tracking scoreboard: own copy of slot state, queue of awaited result words
    class tracker_scoreboard;
        logic [IDS_W-1:0]   ids;
        logic [KINDS_W-1:0] kinds;
        logic [BUSES_W-1:0] buses;
        logic [LIMIT_W-1:0] limit;
        int                 prev_angle [CFG_SLOTS];
        int                 turns [CFG_SLOTS];
        bit                 seen [CFG_SLOTS];
        logic [TICK_W-1:0]  heard [CFG_SLOTS];
        logic [TICK_W-1:0]  tick_now;
        tracker_result_t    awaited[$];
        int                 errors;

        function new();
            ids      = '0;
            kinds    = '0;
            buses    = '0;
            limit    = LIMIT_RST;
            tick_now = '0;
            errors   = 0;
            foreach (prev_angle[i]) begin
                prev_angle[i] = 0;
                turns[i]      = 0;
                seen[i]       = 1'b0;
                heard[i]      = '0;
            end
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SLOT_IDS:   ids   = data[IDS_W-1:0];
                CFG_SLOT_KINDS: kinds = data[KINDS_W-1:0];
                CFG_SLOT_BUSES: buses = data[BUSES_W-1:0];
                CFG_SILENCE:    limit = data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        endfunction

        function motor_kind_t kind_of(int i);
            return motor_kind_t'(kinds[KIND_W*i +: KIND_W]);
        endfunction

        // present slot whose last frame is at least the silence limit old
        function bit slot_silent(int i);
            logic [TICK_W-1:0] age;
            age = tick_now - heard[i];
            return (kind_of(i) != KIND_ABSENT) && (age >= TICK_W'(limit));
        endfunction

        function bit any_silent();
            int i;
            for (i = 0; i < CFG_SLOTS; i++)
                if (slot_silent(i)) return 1'b1;
            return 1'b0;
        endfunction

        // division rounding to nearest, ties away from zero
        function longint round_div(longint n, longint d);
            if (n >= 0) return (n + d / 2) / d;
            return -((-n + d / 2) / d);
        endfunction

        // work out the result word of one accepted input word
        function void note_word(feedback_word_t w);
            tracker_result_t r;
            int              i, slot, ang, spd, diff, thr, cnt;
            longint          ratio, sp, sh;
            motor_kind_t     kind;
            bit              hit;
            r    = '{default: '0};
            hit  = 1'b0;
            slot = 0;
            kind = KIND_ABSENT;
            if (w.action) begin
                tick_now = tick_now + 1'b1;
            end else begin
                // lowest present slot on this bus with this identifier
                for (i = 0; i < CFG_SLOTS && !hit; i++) begin
                    if (kind_of(i) != KIND_ABSENT && buses[i] == w.bus_num &&
                        ids[ID_W*i +: ID_W] == w.frame_id) begin
                        hit  = 1'b1;
                        slot = i;
                        kind = kind_of(i);
                    end
                end
                if (hit && kind == KIND_R36 && w.frame_len != FULL_LEN) hit = 1'b0;
            end
            if (hit) begin
                ang = int'($signed(w.frame_data[63:48]));
                spd = int'($signed(w.frame_data[47:32]));
                case (kind)
                    KIND_R36: begin
                        ratio = 36;
                        thr   = THR_GEARED;
                    end
                    KIND_R19: begin
                        ratio         = 19;
                        thr           = THR_GEARED;
                        r.temperature = w.frame_data[15:8];
                    end
                    default: begin
                        ratio = 1;
                        thr   = THR_DIRECT;
                    end
                endcase
                // wrap detection, first frame taken as its own predecessor
                if (!seen[slot]) prev_angle[slot] = ang;
                diff = ang - prev_angle[slot];
                cnt  = turns[slot];
                if (diff < -thr) cnt++;
                else if (diff > thr) cnt--;
                if (cnt > TURN_CLEAR || cnt < -TURN_CLEAR) cnt = 0;
                turns[slot]      = cnt;
                prev_angle[slot] = ang;
                seen[slot]       = 1'b1;
                heard[slot]      = tick_now;
                sp = round_div(longint'(spd) * 256, ratio);
                sh = round_div((longint'(cnt) * (1 << TURN_SHIFT) + longint'(ang)) *
                               SHAFT_K_DIRECT, ratio);
                r.matched       = 1'b1;
                r.slot_index    = slot[1:0];
                r.raw_angle     = w.frame_data[63:48];
                r.speed_scaled  = sp[SPEED_W-1:0];
                r.motor_current = w.frame_data[31:16];
                r.turn_count    = cnt[TURN_W-1:0];
                r.shaft_angle   = sh[SHAFT_W-1:0];
                r.slot_offline  = slot_silent(slot);
            end
            r.any_offline = any_silent();
            awaited.push_back(r);
        endfunction

        task report(string msg);
            if (errors < MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_field(string name, logic signed [63:0] got, logic signed [63:0] want);
            if (got !== want) report($sformatf("%s got %0d want %0d", name, got, want));
        endtask

        // compare one result word with the oldest awaited one
        task check_word(tracker_result_t got);
            tracker_result_t want;
            if (awaited.size() == 0) begin
                report("result word with nothing awaited");
                return;
            end
            want = awaited.pop_front();
            check_field("matched", got.matched, want.matched);
            check_field("slot_index", got.slot_index, want.slot_index);
            check_field("raw_angle", got.raw_angle, want.raw_angle);
            check_field("speed_scaled", got.speed_scaled, want.speed_scaled);
            check_field("motor_current", got.motor_current, want.motor_current);
            check_field("temperature", got.temperature, want.temperature);
            check_field("turn_count", got.turn_count, want.turn_count);
            check_field("shaft_angle", got.shaft_angle, want.shaft_angle);
            check_field("slot_offline", got.slot_offline, want.slot_offline);
            check_field("any_offline", got.any_offline, want.any_offline);
        endtask
    endclass

    logic                        aclk = 1'b0;
    logic                        aresetn;
    logic                        cfg_wr_en;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_wdata;
    logic                        s_valid;
    logic                        s_ready;
    logic                        s_action;
    logic                        s_bus_num;
    logic [ID_W-1:0]             s_frame_id;
    logic [LEN_W-1:0]            s_frame_len;
    logic [DATA_W-1:0]           s_frame_data;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic                        m_matched;
    logic [1:0]                  m_slot_index;
    logic signed [ANGLE_W-1:0]   m_raw_angle;
    logic signed [SPEED_W-1:0]   m_speed_scaled;
    logic signed [CURR_W-1:0]    m_motor_current;
    logic [TEMP_W-1:0]           m_temperature;
    logic signed [TURN_W-1:0]    m_turn_count;
    logic signed [SHAFT_W-1:0]   m_shaft_angle;
    logic                        m_slot_offline;
    logic                        m_any_offline;

    tracker_scoreboard sb;
    int                idle_pct = 0;
    int                stall_pct = 0;
    int                quiet_cycles = 0;
    logic [IDS_W-1:0]  cur_ids = '0;
    logic [BUSES_W-1:0] cur_buses = '0;
    int                sent_angle [CFG_SLOTS] = '{default: 0};

    motor_feedback_turn_tracker_top i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_bus_num       (s_bus_num),
        .s_frame_id      (s_frame_id),
        .s_frame_len     (s_frame_len),
        .s_frame_data    (s_frame_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_matched       (m_matched),
        .m_slot_index    (m_slot_index),
        .m_raw_angle     (m_raw_angle),
        .m_speed_scaled  (m_speed_scaled),
        .m_motor_current (m_motor_current),
        .m_temperature   (m_temperature),
        .m_turn_count    (m_turn_count),
        .m_shaft_angle   (m_shaft_angle),
        .m_slot_offline  (m_slot_offline),
        .m_any_offline   (m_any_offline)
    );

    // clock
    initial begin
        forever #HALF_PERIOD aclk = ~aclk;
    end

    // result monitor and receiver stalls
    always @(posedge aclk) begin
        tracker_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.matched       = m_matched;
            got.slot_index    = m_slot_index;
            got.raw_angle     = m_raw_angle;
            got.speed_scaled  = m_speed_scaled;
            got.motor_current = m_motor_current;
            got.temperature   = m_temperature;
            got.turn_count    = m_turn_count;
            got.shaft_angle   = m_shaft_angle;
            got.slot_offline  = m_slot_offline;
            got.any_offline   = m_any_offline;
            sb.check_word(got);
        end
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [15:0] rand_half();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // data bytes around a chosen angle: speed, current, temperature, spare byte
    function automatic logic [DATA_W-1:0] feedback_bytes(logic [15:0] ang);
        return {ang, rand_half(), rand_half(), 8'($urandom), 8'($urandom)};
    endfunction

    function automatic feedback_word_t frame_word(logic bus, logic [ID_W-1:0] id,
                                                  logic [LEN_W-1:0] len,
                                                  logic [DATA_W-1:0] data);
        feedback_word_t w;
        w.action     = 1'b0;
        w.bus_num    = bus;
        w.frame_id   = id;
        w.frame_len  = len;
        w.frame_data = data;
        return w;
    endfunction

    // tick word, the frame fields carry noise
    function automatic feedback_word_t tick_word();
        feedback_word_t w;
        w            = frame_word(1'($urandom), 11'($urandom), 4'($urandom_range(0, 8)),
                                  {32'($urandom), 32'($urandom)});
        w.action     = 1'b1;
        return w;
    endfunction

    // present one word after a random gap and hold it until taken
    task automatic send_word(feedback_word_t w);
        int gap;
        gap = 0;
        while (gap < 400 && $urandom_range(0, 99) < idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= w.action;
        s_bus_num    <= w.bus_num;
        s_frame_id   <= w.frame_id;
        s_frame_len  <= w.frame_len;
        s_frame_data <= w.frame_data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_word(w);
    endtask

    // stop sending and let every awaited word come out
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.set_reg(idx, data);
    endtask

    // full register set, written only once the block is idle
    task automatic write_config(logic [IDS_W-1:0] ids, logic [KINDS_W-1:0] kinds,
                                logic [BUSES_W-1:0] buses, logic [LIMIT_W-1:0] limit);
        settle();
        write_reg(CFG_SLOT_IDS, ids);
        write_reg(CFG_SLOT_KINDS, CFG_DATA_W'(kinds));
        write_reg(CFG_SLOT_BUSES, CFG_DATA_W'(buses));
        write_reg(CFG_SILENCE, CFG_DATA_W'(limit));
        cfg_wr_en <= 1'b0;
        cur_ids   = ids;
        cur_buses = buses;
    endtask

    task automatic set_idling(idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            IDLE_SENDER: begin
                idle_pct  = 87;
                stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                idle_pct  = 0;
                stall_pct = 87;
            end
            IDLE_BOTH: begin
                idle_pct  = 37;
                stall_pct = 37;
            end
            default: begin
                idle_pct  = 0;
                stall_pct = 0;
            end
        endcase
    endtask

    task automatic run_directed();
        logic [IDS_W-1:0] ids;
        logic [KINDS_W-1:0] kinds;
        ids   = {11'h7FF, 11'h7FF, 11'h202, 11'h201};
        kinds = {KIND_DIRECT, KIND_DIRECT, KIND_R19, KIND_R36};
        // after reset every slot is absent
        send_word(frame_word(1'b0, '0, FULL_LEN, '0));
        send_word(tick_word());
        write_config(ids, kinds, 4'b0100, 16'd3);
        // ratio 36 slot: first frame, full-scale wraps both ways, short frames ignored
        send_word(frame_word(1'b0, 11'h201, FULL_LEN, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0}));
        send_word(frame_word(1'b0, 11'h201, FULL_LEN, {16'h8000, 16'h8000, 16'h8000, 16'h0}));
        send_word(frame_word(1'b0, 11'h201, FULL_LEN, {16'h7FFF, 16'h1, 16'hFFFF, 16'h5A5A}));
        send_word(frame_word(1'b0, 11'h201, 4'd7, feedback_bytes(16'h0100)));
        send_word(frame_word(1'b0, 11'h201, 4'd0, '1));
        // ratio 19 slot: any length, temperature byte, threshold edges
        send_word(frame_word(1'b0, 11'h202, 4'd0, '1));
        send_word(frame_word(1'b0, 11'h202, FULL_LEN, '0));
        send_word(frame_word(1'b0, 11'h202, FULL_LEN, feedback_bytes(16'(-4097))));
        send_word(frame_word(1'b0, 11'h202, FULL_LEN, feedback_bytes(16'hFFFF)));
        // direct slot on bus 1: just past and exactly at its threshold
        send_word(frame_word(1'b1, 11'h7FF, FULL_LEN, feedback_bytes(16'h0)));
        send_word(frame_word(1'b1, 11'h7FF, FULL_LEN, feedback_bytes(16'(-5501))));
        send_word(frame_word(1'b1, 11'h7FF, FULL_LEN, feedback_bytes(16'h0)));
        send_word(frame_word(1'b1, 11'h7FF, FULL_LEN, feedback_bytes(16'd5500)));
        // same identifier on the other bus goes to the last slot
        send_word(frame_word(1'b0, 11'h7FF, 4'd1, feedback_bytes(16'd1000)));
        // unknown identifier, wrong bus
        send_word(frame_word(1'b1, 11'h000, FULL_LEN, '1));
        send_word(frame_word(1'b1, 11'h202, FULL_LEN, '1));
        // silence: three ticks make every slot offline, a frame revives one
        repeat (4) send_word(tick_word());
        send_word(frame_word(1'b1, 11'h7FF, FULL_LEN, feedback_bytes(16'd200)));
        // zero silence limit: every present slot offline at once
        write_config(ids, kinds, 4'b0100, 16'd0);
        send_word(frame_word(1'b0, 11'h201, FULL_LEN, feedback_bytes(16'h7FFF)));
        send_word(tick_word());
    endtask

    // one revolution of a direct slot: two climbs then a fall, or the mirror
    task automatic spin_turn(int dir);
        int step;
        step = dir * 5000;
        send_word(frame_word(1'b1, SWEEP_ID, FULL_LEN, feedback_bytes(16'(step))));
        send_word(frame_word(1'b1, SWEEP_ID, FULL_LEN, feedback_bytes(16'(2 * step))));
        send_word(frame_word(1'b1, SWEEP_ID, FULL_LEN, feedback_bytes(16'h0)));
    endtask

    // spin a direct slot several turns each way at full rate
    task automatic run_clear_sweep();
        write_config({33'd0, SWEEP_ID}, {6'd0, KIND_DIRECT}, 4'b0001, LIMIT_RST);
        repeat (SWEEP_TURNS) spin_turn(1);
        repeat (SWEEP_TURNS) spin_turn(-1);
    endtask

    // register set of one random phase, extremes first
    task automatic pick_setting(int phase);
        logic [IDS_W-1:0] ids;
        logic [ID_W-1:0]  id;
        logic [LIMIT_W-1:0] limit;
        int i;
        if (phase == 0) begin
            write_config('1, '1, '1, '1);
        end else if (phase == 1) begin
            write_config('0, {KIND_R19, KIND_R36, KIND_DIRECT, KIND_R36}, '0, 16'd1);
        end else begin
            ids = '0;
            for (i = 0; i < CFG_SLOTS; i++) begin
                id = 11'($urandom);
                if (i > 0 && $urandom_range(0, 3) == 0)
                    id = ids[ID_W*$urandom_range(0, i - 1) +: ID_W];
                ids[ID_W*i +: ID_W] = id;
            end
            case ($urandom_range(0, 5))
                0:       limit = 16'd1;
                1:       limit = 16'd2;
                2:       limit = 16'd4;
                3:       limit = 16'd9;
                4:       limit = 16'd25;
                default: limit = 16'($urandom_range(1, 300));
            endcase
            write_config(ids, 8'($urandom), 4'($urandom), limit);
        end
    endtask

    // mostly frames aimed at configured slots with plausible angle motion
    task automatic send_random_word();
        logic [ID_W-1:0]  id;
        logic [LEN_W-1:0] len;
        logic [15:0]      ang;
        logic             bus;
        int               pick, s, step;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            send_word(tick_word());
        end else begin
            s = $urandom_range(0, CFG_SLOTS - 1);
            if (pick < 88) begin
                bus = cur_buses[s];
                id  = cur_ids[ID_W*s +: ID_W];
            end else begin
                bus = 1'($urandom);
                id  = 11'($urandom);
            end
            len = ($urandom_range(0, 9) < 8) ? FULL_LEN : 4'($urandom_range(0, 8));
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: step = int'($urandom_range(0, 6000)) - 3000;
                5, 6, 7:       step = int'($urandom_range(4090, 5510));
                8:             step = int'($urandom_range(8000, 40000));
                default:       step = int'($urandom_range(0, 65535));
            endcase
            if ($urandom_range(0, 1) == 1) step = -step;
            ang = 16'(sent_angle[s] + step);
            sent_angle[s] = int'($signed(ang));
            send_word(frame_word(bus, id, len, feedback_bytes(ang)));
        end
    endtask

    // stimulus and final verdict
    initial begin
        int p;
        sb = new();
        aresetn      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= CFG_SLOT_IDS;
        cfg_wdata    <= '0;
        s_valid      <= 1'b0;
        s_action     <= 1'b0;
        s_bus_num    <= 1'b0;
        s_frame_id   <= '0;
        s_frame_len  <= '0;
        s_frame_data <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_idling(IDLE_NONE);
        run_directed();
        run_clear_sweep();
        for (p = 0; p < RANDOM_PHASES; p++) begin
            pick_setting(p);
            set_idling(idle_mode_t'(p % 4));
            repeat (WORDS_PER_PHASE) send_random_word();
        end
        settle();
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### motor_feedback_turn_tracker_top.f
+incdir+sv
sv/mftt_pkg.sv
sv/motor_feedback_turn_tracker_top.sv
test/motor_feedback_turn_tracker_top_tb.sv
